@@ sv/swpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Sync word packet deframer package
// Shared types and constants for the deframer: configuration bundle,
// register indexes, frame stages and the result record.
// ----------------------------------------------------------------------------
package swpd_pkg;

	localparam int unsigned NUM_TYPES  = 4;
	localparam int unsigned LEN_REGS   = 4;
	localparam int unsigned LEN_IDX_W  = $clog2(LEN_REGS);
	localparam int unsigned TYPE_LIMIT = (NUM_TYPES < LEN_REGS) ? NUM_TYPES : LEN_REGS;
	localparam logic [7:0]  HEADER_LEN = 8'd3;

	typedef enum logic [2:0] {
		REG_SYNC_FIRST     = 3'd0,
		REG_SYNC_SECOND    = 3'd1,
		REG_MATCH_ANY_TYPE = 3'd2,
		REG_WANTED_TYPE    = 3'd3,
		REG_LEN_TYPE_ZERO  = 3'd4,
		REG_LEN_TYPE_ONE   = 3'd5,
		REG_LEN_TYPE_TWO   = 3'd6,
		REG_LEN_TYPE_THREE = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_HUNT    = 2'd0,
		ST_SYNC1   = 2'd1,
		ST_SYNC2   = 2'd2,
		ST_PAYLOAD = 2'd3
	} stage_t;

	typedef struct packed {
		logic [7:0]                   sync_first;
		logic [7:0]                   sync_second;
		logic                         match_any_type;
		logic [7:0]                   wanted_type;
		logic [LEN_REGS-1:0][7:0]     type_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_type;
		logic       last;
	} result_t;

endpackage

@@ sv/swpd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the sync bytes, type filter and per-type packet lengths, written
// through a simple indexed write port.
// ----------------------------------------------------------------------------
module swpd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output swpd_pkg::cfg_t cfg
);
	import swpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first     <= 8'd0;
			cfg_q.sync_second    <= 8'd0;
			cfg_q.match_any_type <= 1'b1;
			cfg_q.wanted_type    <= 8'd0;
			for (int i = 0; i < LEN_REGS; i++) begin
				cfg_q.type_len[i] <= HEADER_LEN;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_SYNC_FIRST:     cfg_q.sync_first     <= cfg_data;
				REG_SYNC_SECOND:    cfg_q.sync_second    <= cfg_data;
				REG_MATCH_ANY_TYPE: cfg_q.match_any_type <= cfg_data[0];
				REG_WANTED_TYPE:    cfg_q.wanted_type    <= cfg_data;
				REG_LEN_TYPE_ZERO:  cfg_q.type_len[0]    <= cfg_data;
				REG_LEN_TYPE_ONE:   cfg_q.type_len[1]    <= cfg_data;
				REG_LEN_TYPE_TWO:   cfg_q.type_len[2]    <= cfg_data;
				REG_LEN_TYPE_THREE: cfg_q.type_len[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/swpd_frame.sv @@
// ----------------------------------------------------------------------------
// Deframer frame engine
// Registers each received byte, then advances the frame state machine and
// decides whether the byte produces a result.
// ----------------------------------------------------------------------------
module swpd_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  swpd_pkg::cfg_t    cfg,
	input  logic              res_free,
	output logic              res_load,
	output swpd_pkg::result_t res
);
	import swpd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	stage_t     stage_q, stage_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic       adv;
	logic       type_ok;
	logic [7:0] type_len;
	logic [7:0] payload;
	logic       hit;

	// The held byte is consumed whenever the result register can take a result.
	assign adv      = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign type_ok  = (byte_s1 < 8'(TYPE_LIMIT)) &&
		(cfg.match_any_type || (byte_s1 == cfg.wanted_type));
	assign type_len = cfg.type_len[byte_s1[LEN_IDX_W-1:0]];
	assign payload  = (type_len < HEADER_LEN) ? 8'd0 : type_len - HEADER_LEN;

	always_comb begin
		stage_d      = stage_q;
		bytes_left_d = bytes_left_q;
		unique case (stage_q)
			ST_HUNT: begin
				if (byte_s1 == cfg.sync_first) stage_d = ST_SYNC1;
			end
			ST_SYNC1: begin
				stage_d = (byte_s1 == cfg.sync_second) ? ST_SYNC2 : ST_HUNT;
			end
			ST_SYNC2: begin
				if (!type_ok || payload == 8'd0) begin
					stage_d = ST_HUNT;
					if (type_ok) bytes_left_d = 8'd0;
				end else begin
					stage_d      = ST_PAYLOAD;
					bytes_left_d = payload;
				end
			end
			ST_PAYLOAD: begin
				if (bytes_left_q <= 8'd1) begin
					stage_d      = ST_HUNT;
					bytes_left_d = 8'd0;
				end else begin
					bytes_left_d = bytes_left_q - 8'd1;
				end
			end
			default: stage_d = ST_HUNT;
		endcase
	end

	always_comb begin
		hit          = 1'b0;
		res.out_byte = byte_s1;
		res.is_type  = 1'b0;
		res.last     = 1'b0;
		unique case (stage_q) inside
			ST_HUNT, ST_SYNC1: hit = 1'b0;
			ST_SYNC2: begin
				hit         = type_ok;
				res.is_type = 1'b1;
				res.last    = (payload == 8'd0);
			end
			ST_PAYLOAD: begin
				hit      = 1'b1;
				res.last = (bytes_left_q <= 8'd1);
			end
			default: hit = 1'b0;
		endcase
	end

	assign res_load = adv && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q      <= ST_HUNT;
			bytes_left_q <= 8'd0;
		end else if (adv) begin
			stage_q      <= stage_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

@@ sv/swpd_out_reg.sv @@
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until the downstream side takes it, and can be reloaded
// in the same cycle that the held result leaves.
// ----------------------------------------------------------------------------
module swpd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  swpd_pkg::result_t res,
	output logic              res_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              is_type,
	output logic              last
);
	import swpd_pkg::*;

	logic    out_valid_q;
	result_t res_q;

	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = res_q.out_byte;
	assign is_type   = res_q.is_type;
	assign last      = res_q.last;

endmodule

@@ sv/sync_word_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// Sync word packet deframer
// Hunts for a two-byte sync word, filters on the packet type and passes the
// type byte and the payload bytes on with a last-byte mark.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle for as long as the output side
// keeps up. A byte is held in an input register while the frame state and
// byte counter are updated, and any result it gives is then loaded into the
// output register once that register is free, so each result passes through
// the input register and then the output register before it reaches the
// output ports. The frame state register is updated once per consumed byte;
// a held result stalls the input only when the output side holds off ready.
// Configuration should be written only while no bytes are in flight.
module sync_word_packet_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_type,
	output logic       last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import swpd_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    res_load;
	logic    res_free;

	swpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swpd_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	swpd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.res_free  (res_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.is_type   (is_type),
		.last      (last)
	);

endmodule

@@ sv/swpd_checker.sv @@
// ----------------------------------------------------------------------------
// Deframer port checker
// Concurrent checks on the top level's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module swpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_type,
	input logic       last
);
	import swpd_pkg::*;

	// A stalled result must hold its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(is_type) && $stable(last))
		else $error("stalled result changed");

	// A type byte can only name a type the length table covers.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_type |-> out_byte < 8'(TYPE_LIMIT))
		else $error("type byte outside the type table");

	// With the result register empty, the input side is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// After the last byte of a packet the block hunts for sync, so no result
	// can follow in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("result directly after end of packet");

endmodule

bind sync_word_packet_deframer_core swpd_checker u_swpd_checker (.*);
